// ===== hdl/srm_pkg.sv =====
// types and constants shared by the strain rate magnitude pipeline
// no dependencies; every other file in hdl/ refers to it by scoped names
package srm_pkg;

  localparam int GRAD_W = 32;
  localparam int S_W    = GRAD_W + 1;   // off-diagonal sum g_ij + g_ji
  localparam int D_W    = GRAD_W + 2;   // diagonal term 3*g_ii - trace
  localparam int SQ_W   = 66;           // one squared term
  localparam int S2_W   = 66;           // sum of the off-diagonal squares
  localparam int D2_W   = 68;           // sum of the diagonal squares
  localparam int Q_W    = 71;           // 18*S2 + 4*D2
  localparam int REM_W  = 69;           // root remainder, Q below the clip limit
  localparam int ROOT_W = 32;
  localparam int DIMS_W = 2;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;
  localparam logic [DIMS_W-1:0] DIMS_2D    = 2'd2;

  // result above 32 bits exactly when Q >= 18 * 2^64
  localparam logic [Q_W-1:0] SAT_LIM = Q_W'(18) << 64;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad_xx;
    logic signed [GRAD_W-1:0] grad_xy;
    logic signed [GRAD_W-1:0] grad_xz;
    logic signed [GRAD_W-1:0] grad_yx;
    logic signed [GRAD_W-1:0] grad_yy;
    logic signed [GRAD_W-1:0] grad_yz;
    logic signed [GRAD_W-1:0] grad_zx;
    logic signed [GRAD_W-1:0] grad_zy;
    logic signed [GRAD_W-1:0] grad_zz;
  } grad_t;

  typedef struct packed {
    logic [ROOT_W-1:0] magnitude;
    logic              saturated;
  } result_t;

  typedef struct packed {
    logic signed [S_W-1:0] s_xy;
    logic signed [S_W-1:0] s_xz;
    logic signed [S_W-1:0] s_yz;
    logic signed [D_W-1:0] d_x;
    logic signed [D_W-1:0] d_y;
    logic signed [D_W-1:0] d_z;
  } terms_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              sat;
  } root_t;

endpackage

// ===== hdl/srm_front.sv =====
// first pipeline stage: symmetric sums and deviatoric diagonal terms
// depends on srm_pkg
module srm_front (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic           is_2d_i,
  input  srm_pkg::grad_t grad_i,
  output srm_pkg::terms_t terms_o
);

  srm_pkg::terms_t terms_d, terms_q;

  logic signed [srm_pkg::D_W-1:0] xx, yy, zz;
  logic signed [srm_pkg::S_W-1:0] xy, yx, xz, zx, yz, zy;

  always_comb begin
    xx = srm_pkg::D_W'(grad_i.grad_xx);
    yy = srm_pkg::D_W'(grad_i.grad_yy);
    zz = is_2d_i ? '0 : srm_pkg::D_W'(grad_i.grad_zz);
    xy = srm_pkg::S_W'(grad_i.grad_xy);
    yx = srm_pkg::S_W'(grad_i.grad_yx);
    xz = srm_pkg::S_W'(grad_i.grad_xz);
    zx = srm_pkg::S_W'(grad_i.grad_zx);
    yz = srm_pkg::S_W'(grad_i.grad_yz);
    zy = srm_pkg::S_W'(grad_i.grad_zy);

    terms_d.s_xy = xy + yx;
    terms_d.s_xz = is_2d_i ? '0 : xz + zx;
    terms_d.s_yz = is_2d_i ? '0 : yz + zy;
    // 3*g_ii - trace, z dropped from the trace in 2d
    terms_d.d_x  = (xx <<< 1) - yy - zz;
    terms_d.d_y  = (yy <<< 1) - xx - zz;
    terms_d.d_z  = is_2d_i ? '0 : (zz <<< 1) - xx - yy;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      terms_q <= terms_d;
    end
  end

  assign terms_o = terms_q;

endmodule

// ===== hdl/srm_energy.sv =====
// stages two to four: squares, partial sums and the scaled sum Q = 18*S2 + 4*D2
// depends on srm_pkg
module srm_energy (
  input  logic                      clk_i,
  input  logic [2:0]                en_i,
  input  srm_pkg::terms_t           terms_i,
  output logic [srm_pkg::Q_W-1:0]   q_o
);

  logic signed [2*srm_pkg::S_W-1:0] p_xy, p_xz, p_yz;
  logic signed [2*srm_pkg::D_W-1:0] p_x, p_y, p_z;

  logic [srm_pkg::SQ_W-1:0] sq_xy_q, sq_xz_q, sq_yz_q, sq_x_q, sq_y_q, sq_z_q;
  logic [srm_pkg::S2_W-1:0] s2_d, s2_q;
  logic [srm_pkg::D2_W-1:0] d2_d, d2_q;
  logic [srm_pkg::Q_W-1:0]  q_d, q_q;

  always_comb begin
    p_xy = terms_i.s_xy * terms_i.s_xy;
    p_xz = terms_i.s_xz * terms_i.s_xz;
    p_yz = terms_i.s_yz * terms_i.s_yz;
    p_x  = terms_i.d_x * terms_i.d_x;
    p_y  = terms_i.d_y * terms_i.d_y;
    p_z  = terms_i.d_z * terms_i.d_z;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sq_xy_q <= srm_pkg::SQ_W'(p_xy);
      sq_xz_q <= srm_pkg::SQ_W'(p_xz);
      sq_yz_q <= srm_pkg::SQ_W'(p_yz);
      sq_x_q  <= p_x[srm_pkg::SQ_W-1:0];
      sq_y_q  <= p_y[srm_pkg::SQ_W-1:0];
      sq_z_q  <= p_z[srm_pkg::SQ_W-1:0];
    end
  end

  always_comb begin
    s2_d = sq_xy_q + sq_xz_q + sq_yz_q;
    d2_d = srm_pkg::D2_W'(sq_x_q) + srm_pkg::D2_W'(sq_y_q) + srm_pkg::D2_W'(sq_z_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q <= s2_d;
      d2_q <= d2_d;
    end
  end

  // off-diagonal pairs count twice with factor 9, diagonal carries factor 4
  assign q_d = (srm_pkg::Q_W'(s2_q) << 4) + (srm_pkg::Q_W'(s2_q) << 1)
             + (srm_pkg::Q_W'(d2_q) << 2);

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// ===== hdl/srm_sqrt_step.sv =====
// one bit of the scaled integer square root: largest r with 18*r^2 <= Q
// depends on srm_pkg
module srm_sqrt_step #(
  parameter int K = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  srm_pkg::root_t  root_i,
  output srm_pkg::root_t  root_o
);

  logic [srm_pkg::REM_W-1:0] base;
  logic [srm_pkg::REM_W-1:0] trial;
  srm_pkg::root_t            root_d, root_q;

  always_comb begin
    // 18*((r+2^K)^2 - r^2) = 18*(r*2^(K+1) + 2^(2K))
    base   = (srm_pkg::REM_W'(root_i.root) << (K + 1)) | (srm_pkg::REM_W'(1) << (2 * K));
    trial  = (base << 4) + (base << 1);
    root_d = root_i;
    if (root_i.rem >= trial) begin
      root_d.rem  = root_i.rem - trial;
      root_d.root = root_i.root | (srm_pkg::ROOT_W'(1) << K);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
    end
  end

  assign root_o = root_q;

endmodule

// ===== hdl/strain_rate_magnitude_top.sv =====
// top level of the deviatoric strain rate magnitude pipeline
// depends on srm_pkg, srm_front, srm_energy and srm_sqrt_step
//
// Takes one 3x3 velocity gradient per transfer (signed fixed point, any
// fraction width, as long as input and output share it) and returns
// sqrt(2*S:S) of its deviatoric symmetric part, truncated toward zero and
// clipped to all ones with the saturated flag set. The dims register picks
// 2d (code 2, every z field ignored) or 3d (any other code); it resets to 3
// and should only be written while no item is in flight. One item enters per
// clock while in_stall_o is low, so the sustained rate is one item per cycle
// without stalls; there are 37 register stages: one stage of sums, three of
// squares and scaled summation, 32 stages of the square root recurrence (one
// root bit per stage, which sets the depth) and the output register. The item
// lands in the first stage at the input transfer and moves on one stage each
// time the next stage may load, until it reaches the output register. Stalls
// hold the whole occupied tail of the pipeline while empty stages upstream
// keep filling, so input is refused only when every stage holds an item and
// the output is stalled.
module strain_rate_magnitude_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  srm_pkg::grad_t             in_data_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output srm_pkg::result_t           out_data_o,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [srm_pkg::DIMS_W-1:0] cfg_data_i
);

  // stage map: 0 front, 1..3 energy, 4..35 root bits 31..0, 36 output
  localparam int NST       = 37;
  localparam int ROOT_BASE = 4;
  localparam int OUT_STG   = NST - 1;

  logic [srm_pkg::DIMS_W-1:0] dims_q;
  logic [NST-1:0]             v_d, v_q;
  logic [NST-1:0]             full;   // this stage and all stages after it hold items
  logic [NST-1:0]             adv;    // stage may load this cycle

  srm_pkg::terms_t            terms;
  logic [srm_pkg::Q_W-1:0]    q;
  srm_pkg::root_t             chain [0:srm_pkg::ROOT_W];
  srm_pkg::result_t           out_d, out_q;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= srm_pkg::DIMS_RESET;
    end else if (cfg_valid_i) begin
      dims_q <= cfg_data_i;
    end
  end

  // stall propagates back only through a run of occupied stages
  for (genvar i = 0; i < NST; i++) begin : g_full
    assign full[i] = &v_q[NST-1:i];
  end

  assign adv        = ~(full & {NST{out_stall_i}});
  assign in_stall_o = ~adv[0];

  always_comb begin
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NST; i++) begin
      v_d[i] = adv[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // symmetric sums and diagonal terms
  srm_front u_front (
    .clk_i   (clk_i),
    .en_i    (adv[0]),
    .is_2d_i (dims_q == srm_pkg::DIMS_2D),
    .grad_i  (in_data_i),
    .terms_o (terms)
  );

  // squares and the scaled sum
  srm_energy u_energy (
    .clk_i   (clk_i),
    .en_i    (adv[3:1]),
    .terms_i (terms),
    .q_o     (q)
  );

  // clip test runs beside the first root bit; remainder below the limit fits
  always_comb begin
    chain[0].rem  = q[srm_pkg::REM_W-1:0];
    chain[0].root = '0;
    chain[0].sat  = (q >= srm_pkg::SAT_LIM);
  end

  for (genvar k = 0; k < srm_pkg::ROOT_W; k++) begin : g_root
    srm_sqrt_step #(
      .K (srm_pkg::ROOT_W - 1 - k)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (adv[ROOT_BASE + k]),
      .root_i (chain[k]),
      .root_o (chain[k+1])
    );
  end

  // output register
  always_comb begin
    out_d.saturated = chain[srm_pkg::ROOT_W].sat;
    out_d.magnitude = chain[srm_pkg::ROOT_W].sat ? '1 : chain[srm_pkg::ROOT_W].root;
  end

  always_ff @(posedge clk_i) begin
    if (adv[OUT_STG]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[OUT_STG];
  assign out_data_o  = out_q;

  // a clipped result always carries the all-ones magnitude
  a_sat_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.saturated) |-> (out_data_o.magnitude == '1))
    else $error("saturated result without all-ones magnitude");

  // input is refused only when the output is stalled with a result waiting
  a_stall_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&v_q)))
    else $error("input stalled while the pipeline has room");

  // an item held in the first stage is not lost while it waits
  a_front_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !adv[1]) |=> v_q[0])
    else $error("front stage item dropped during stall");

endmodule
